[src/srs_pkg.sv]
`timescale 1ns / 1ps
package srs_pkg;

	localparam int STEP_COUNT_BITS_DEF = 16;
	localparam int DELAY_BITS_DEF      = 7;

	localparam int CFG_W      = 6;
	localparam int CFG_IDX_W  = 3;
	localparam int PHASES     = 4;
	localparam int DWELL_W    = 7;
	localparam int COUNT_W    = 16;

	localparam logic FUNC_TICK = 1'b0;
	localparam logic FUNC_MOVE = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PATTERN_0  = 3'd0,
		REG_PATTERN_1  = 3'd1,
		REG_PATTERN_2  = 3'd2,
		REG_PATTERN_3  = 3'd3,
		REG_START      = 3'd4,
		REG_MIN        = 3'd5,
		REG_LEAD       = 3'd6,
		REG_DECEL      = 3'd7
	} reg_idx_t;

	localparam logic [CFG_W-1:0] RST_PATTERN_0 = 6'b110000;
	localparam logic [CFG_W-1:0] RST_PATTERN_1 = 6'b000110;
	localparam logic [CFG_W-1:0] RST_PATTERN_2 = 6'b101000;
	localparam logic [CFG_W-1:0] RST_PATTERN_3 = 6'b000101;
	localparam logic [CFG_W-1:0] RST_START     = 6'd20;
	localparam logic [CFG_W-1:0] RST_MIN       = 6'd1;
	localparam logic [CFG_W-1:0] RST_LEAD      = 6'd10;
	localparam logic [CFG_W-1:0] RST_DECEL     = 6'd19;

	typedef struct packed {
		logic [PHASES-1:0][CFG_W-1:0] phase_pattern;
		logic [CFG_W-1:0]             start_delay;
		logic [CFG_W-1:0]             min_delay;
		logic [CFG_W-1:0]             lead_steps;
		logic [CFG_W-1:0]             decel_steps;
	} cfg_t;

	typedef struct packed {
		logic               func;
		logic [COUNT_W-1:0] step_count;
		logic               direction;
	} cmd_item_t;

	typedef struct packed {
		logic [CFG_W-1:0]   coil_pattern;
		logic               busy_res;
		logic               step_done;
		logic               move_done;
		logic               rejected;
		logic [DWELL_W-1:0] dwell_now;
	} res_item_t;

endpackage

[src/srs_cfg_regs.sv]
`timescale 1ns / 1ps
module srs_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [srs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [srs_pkg::CFG_W-1:0]      cfg_data,
	output srs_pkg::cfg_t                  cfg
);

	srs_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.phase_pattern[0] <= srs_pkg::RST_PATTERN_0;
			cfg_q.phase_pattern[1] <= srs_pkg::RST_PATTERN_1;
			cfg_q.phase_pattern[2] <= srs_pkg::RST_PATTERN_2;
			cfg_q.phase_pattern[3] <= srs_pkg::RST_PATTERN_3;
			cfg_q.start_delay      <= srs_pkg::RST_START;
			cfg_q.min_delay        <= srs_pkg::RST_MIN;
			cfg_q.lead_steps       <= srs_pkg::RST_LEAD;
			cfg_q.decel_steps      <= srs_pkg::RST_DECEL;
		end else if (cfg_we) begin
			case (srs_pkg::reg_idx_t'(cfg_index))
				srs_pkg::REG_PATTERN_0: cfg_q.phase_pattern[0] <= cfg_data;
				srs_pkg::REG_PATTERN_1: cfg_q.phase_pattern[1] <= cfg_data;
				srs_pkg::REG_PATTERN_2: cfg_q.phase_pattern[2] <= cfg_data;
				srs_pkg::REG_PATTERN_3: cfg_q.phase_pattern[3] <= cfg_data;
				srs_pkg::REG_START:     cfg_q.start_delay      <= cfg_data;
				srs_pkg::REG_MIN:       cfg_q.min_delay        <= cfg_data;
				srs_pkg::REG_LEAD:      cfg_q.lead_steps       <= cfg_data;
				srs_pkg::REG_DECEL:     cfg_q.decel_steps      <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[src/stepper_ramp_sequencer_core.sv]
`timescale 1ns / 1ps
// Trapezoidal-ramp stepper sequencer.
// Command channel (cmd_valid/cmd_ready/cmd_data): each beat is either a
// millisecond tick (func 0) or a move command (func 1, step count and
// direction). Result channel (res_valid/res_ready/res_data): exactly one
// beat per command beat, carrying the coil pattern, busy flag, step and
// move completion flags, the reject flag and the dwell now in force.
// Configuration port (cfg_we/cfg_index/cfg_data): writes to the
// four phase patterns and the ramp settings; write only while idle.
// The result of an accepted beat is registered and shows from the next cycle.
// Throughput is one beat per cycle while results drain; the state update is a
// short add/compare chain between the state registers and the result register.
// cmd_ready stays high while the result register is empty or being drained,
// so a stalled receiver holds at most one result and then stalls the sender.
// Reset clears the motion state, the coil pattern to zero and the result
// valid flag, and loads the default patterns and ramp settings.
module stepper_ramp_sequencer_core #(
	parameter int STEP_COUNT_BITS = srs_pkg::STEP_COUNT_BITS_DEF,
	parameter int DELAY_BITS      = srs_pkg::DELAY_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cmd_valid,
	output logic                           cmd_ready,
	input  srs_pkg::cmd_item_t             cmd_data,
	output logic                           res_valid,
	input  logic                           res_ready,
	output srs_pkg::res_item_t             res_data,
	input  logic                           cfg_we,
	input  logic [srs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [srs_pkg::CFG_W-1:0]      cfg_data
);

	localparam int SB = STEP_COUNT_BITS;
	localparam int DB = DELAY_BITS;
	localparam int CW = srs_pkg::CFG_W;

	srs_pkg::cfg_t cfg;

	srs_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// motion state
	logic [1:0]    phase_q,  phase_n;
	logic [SB-1:0] step_q,   step_n;
	logic [SB-1:0] len_q,    len_n;
	logic [DB-1:0] delay_q,  delay_n;
	logic [DB-1:0] tick_q,   tick_n;
	logic          ccw_q,    ccw_n;
	logic          moving_q, moving_n;
	logic [CW-1:0] drive_q,  drive_n;

	logic step_done, move_done, rejected;

	logic               res_valid_q;
	srs_pkg::res_item_t res_data_q;

	logic accept;

	// width-safe extensions of register fields
	logic [DB+CW-1:0] start_wide, min_wide;
	logic [SB+CW:0]   lead_wide, decel_wide;
	logic [SB+srs_pkg::COUNT_W-1:0] count_wide;
	logic [DB-1:0]    start_ext, min_ext;
	logic [SB:0]      lead_ext, decel_ext;
	logic [SB-1:0]    cmd_len;
	logic [DB+srs_pkg::DWELL_W-1:0] dwell_wide;

	assign start_wide = {{DB{1'b0}}, cfg.start_delay};
	assign min_wide   = {{DB{1'b0}}, cfg.min_delay};
	assign start_ext  = start_wide[DB-1:0];
	assign min_ext    = min_wide[DB-1:0];
	assign lead_wide  = {{(SB+1){1'b0}}, cfg.lead_steps};
	assign decel_wide = {{(SB+1){1'b0}}, cfg.decel_steps};
	assign lead_ext   = lead_wide[SB:0];
	assign decel_ext  = decel_wide[SB:0];
	assign count_wide = {{SB{1'b0}}, cmd_data.step_count};
	assign cmd_len    = count_wide[SB-1:0];

	assign cmd_ready = !res_valid_q || res_ready;
	assign accept    = cmd_valid && cmd_ready;

	// true when the step at idx is in the acceleration part of the move
	function automatic logic in_accel(input logic [SB-1:0] idx, input logic [SB-1:0] len,
			input logic [SB:0] lead, input logic [SB:0] decel);
		logic [SB:0] idx_w;
		idx_w = {1'b0, idx};
		return (idx_w >= lead) && ((idx_w + decel) < {1'b0, len});
	endfunction

	always_comb begin
		phase_n   = phase_q;
		step_n    = step_q;
		len_n     = len_q;
		delay_n   = delay_q;
		tick_n    = tick_q;
		ccw_n     = ccw_q;
		moving_n  = moving_q;
		drive_n   = drive_q;
		step_done = 1'b0;
		move_done = 1'b0;
		rejected  = 1'b0;
		if (cmd_data.func == srs_pkg::FUNC_MOVE) begin
			if (moving_q) begin
				rejected = 1'b1;
			end else begin
				len_n   = cmd_len;
				ccw_n   = cmd_data.direction;
				delay_n = start_ext;
				step_n  = '0;
				tick_n  = '0;
				if (cmd_len == '0) begin
					move_done = 1'b1;
				end else begin
					moving_n = 1'b1;
					if (in_accel('0, cmd_len, lead_ext, decel_ext) && (start_ext > min_ext))
						delay_n = start_ext - 1'b1;
					drive_n = cfg.phase_pattern[phase_q];
				end
			end
		end else if (moving_q) begin
			tick_n = tick_q + 1'b1;
			if (tick_n >= delay_q) begin
				step_done = 1'b1;
				// grow the dwell in the final region
				if (({1'b0, step_q} >= lead_ext) && (({1'b0, step_q} + decel_ext) >= {1'b0, len_q})
						&& (delay_q != {DB{1'b1}}))
					delay_n = delay_q + 1'b1;
				phase_n = ccw_q ? phase_q - 2'd1 : phase_q + 2'd1;
				step_n  = step_q + 1'b1;
				tick_n  = '0;
				if (step_n == len_q) begin
					moving_n  = 1'b0;
					move_done = 1'b1;
				end else begin
					if (in_accel(step_n, len_q, lead_ext, decel_ext) && (delay_n > min_ext))
						delay_n = delay_n - 1'b1;
					drive_n = cfg.phase_pattern[phase_n];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= '0;
			step_q   <= '0;
			len_q    <= '0;
			delay_q  <= '0;
			tick_q   <= '0;
			ccw_q    <= 1'b0;
			moving_q <= 1'b0;
			drive_q  <= '0;
		end else if (accept) begin
			phase_q  <= phase_n;
			step_q   <= step_n;
			len_q    <= len_n;
			delay_q  <= delay_n;
			tick_q   <= tick_n;
			ccw_q    <= ccw_n;
			moving_q <= moving_n;
			drive_q  <= drive_n;
		end
	end

	assign dwell_wide = {{srs_pkg::DWELL_W{1'b0}}, delay_n};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// hold the payload while the receiver stalls
	always_ff @(posedge clk) begin
		if (accept) begin
			res_data_q.coil_pattern <= drive_n;
			res_data_q.busy_res     <= moving_n;
			res_data_q.step_done    <= step_done;
			res_data_q.move_done    <= move_done;
			res_data_q.rejected     <= rejected;
			res_data_q.dwell_now    <= moving_n ? dwell_wide[srs_pkg::DWELL_W-1:0] : '0;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_data_q;

endmodule
